// ===== src/mcr_pkg.sv =====
// Package for the midpoint circle rasterizer.
// Holds field widths, register indexes, the queued job record and the config record.
// No dependencies.
`default_nettype none
package mcr_pkg;

  localparam int unsigned COORD_W     = 14;
  localparam int unsigned ERR_W       = 16;
  localparam int unsigned CALC_W      = 20;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned DIM_W       = 12;
  localparam int unsigned PIX_W       = 15;
  localparam int unsigned INDEX_W     = 20;
  localparam int unsigned SUM_W       = 25;
  localparam int unsigned MAX_PIXELS  = 1048576;

  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam logic [CFG_ADDR_W-1:0] REG_DRAW_EN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PITCH    = 2'd3;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [2:0] LAST_POINT = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               done;
    logic               empty;
  } job_t;

  typedef struct packed {
    logic             draw_en;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] pitch;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/mcr_front.sv =====
// Front end: accepts items, runs the midpoint error recurrence, builds one job per item.
// Depends on mcr_pkg.
`default_nettype none
module mcr_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  input  wire                          action,
  input  wire  [mcr_pkg::COORD_W-1:0]  center_x,
  input  wire  [mcr_pkg::COORD_W-1:0]  center_y,
  input  wire  [mcr_pkg::COORD_W-1:0]  radius,
  input  wire  [mcr_pkg::COLOR_W-1:0]  draw_color,
  output mcr_pkg::job_t                job
);
  import mcr_pkg::*;

  logic [COORD_W-1:0] cx_r, cy_r, walk_x_r, walk_y_r;
  logic [ERR_W-1:0]   walk_err_r;
  logic [COLOR_W-1:0] color_r;
  logic               active_r;

  logic               start, neg;
  logic [COORD_W-1:0] x0, y0, cx0, cy0;
  logic [ERR_W-1:0]   e0;
  logic [COLOR_W-1:0] color0;
  logic signed [CALC_W-1:0] x0_s, y0_s, e0_s, y1_s, e1_s, t_s, x1_s, e2_s;
  logic               done;
  logic               active_nxt;

  always_comb begin
    start  = (action == ACT_START);
    neg    = radius[COORD_W-1];
    x0     = start ? radius     : walk_x_r;
    y0     = start ? '0         : walk_y_r;
    e0     = start ? '0         : walk_err_r;
    cx0    = start ? center_x   : cx_r;
    cy0    = start ? center_y   : cy_r;
    color0 = start ? draw_color : color_r;

    x0_s = {{(CALC_W-COORD_W){x0[COORD_W-1]}}, x0};
    y0_s = {{(CALC_W-COORD_W){y0[COORD_W-1]}}, y0};
    e0_s = {{(CALC_W-ERR_W){e0[ERR_W-1]}}, e0};
    y1_s = y0_s + 20'sd1;
    e1_s = e0_s + 20'sd1 + (y1_s <<< 1);
    t_s  = ((e1_s - x0_s) <<< 1) + 20'sd1;
    if (t_s > 20'sd0) begin
      x1_s = x0_s - 20'sd1;
      e2_s = e1_s + 20'sd1 - (x1_s <<< 1);
    end else begin
      x1_s = x0_s;
      e2_s = e1_s;
    end
    done = $signed(x1_s[COORD_W-1:0]) < $signed(y1_s[COORD_W-1:0]);

    job.cx    = cx0;
    job.cy    = cy0;
    job.x     = x0;
    job.y     = y0;
    job.color = color0;
    job.done  = done;
    job.empty = start ? neg : !active_r;

    if (start) active_nxt = !neg && !done;
    else       active_nxt = active_r && !done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r       <= '0;
      cy_r       <= '0;
      color_r    <= '0;
      walk_x_r   <= '0;
      walk_y_r   <= '0;
      walk_err_r <= '0;
      active_r   <= 1'b0;
    end else if (push) begin
      active_r <= active_nxt;
      if (!job.empty) begin
        cx_r       <= cx0;
        cy_r       <= cy0;
        color_r    <= color0;
        walk_x_r   <= x1_s[COORD_W-1:0];
        walk_y_r   <= y1_s[COORD_W-1:0];
        walk_err_r <= e2_s[ERR_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/mcr_queue.sv =====
// Short job queue between front end and point generator.
// Depends on mcr_pkg.
`default_nettype none
module mcr_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  mcr_pkg::job_t  push_job,
  output logic           full,
  input  wire            pop,
  output logic           head_valid,
  output mcr_pkg::job_t  head_job
);
  import mcr_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == QCNT_W'(QUEUE_DEPTH));
    head_valid = (count_r != '0);
    head_job   = slot_r[rd_ptr_r];
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

// ===== src/mcr_back.sv =====
// Back end: walks the eight octant points of each job, clips them, forms the buffer index.
// Three stages (select/clip, multiply, add/limit) into the output register. Depends on mcr_pkg.
`default_nettype none
module mcr_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  mcr_pkg::cfg_t                  cfg,
  input  wire                            head_valid,
  input  mcr_pkg::job_t                  head_job,
  output logic                           pop,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [mcr_pkg::OUT_DATA_W-1:0] out_tdata,   // write_enable, pixel_index, pixel_color
  output logic                           out_tlast,
  output logic                           out_tuser    // circle_done
);
  import mcr_pkg::*;

  logic       advance, issue, last_pt;
  logic [2:0] pt_r;
  logic       swap, xneg, yneg;
  logic signed [PIX_W-1:0] cx_s, cy_s, a_s, b_s, px_s, py_s;
  logic       in_frame;

  logic               v1_r, we1_r, last1_r, done1_r;
  logic [DIM_W-1:0]   px1_r, py1_r;
  logic [COLOR_W-1:0] color1_r;

  logic               v2_r, we2_r, last2_r, done2_r;
  logic [DIM_W-1:0]   px2_r;
  logic [2*DIM_W-1:0] prod2_r;
  logic [COLOR_W-1:0] color2_r;

  logic               v3_r, we3_r, last3_r, done3_r;
  logic [INDEX_W-1:0] idx3_r;
  logic [COLOR_W-1:0] color3_r;

  logic [SUM_W-1:0]   sum;
  logic               we3_nxt;

  always_comb begin
    advance = !v3_r || out_tready;
    issue   = head_valid && advance;
    last_pt = head_job.empty || (pt_r == LAST_POINT);
    pop     = issue && last_pt;

    swap = pt_r[0] ^ pt_r[1];
    xneg = pt_r[1] ^ pt_r[2];
    yneg = pt_r[2];
    cx_s = PIX_W'($signed(head_job.cx));
    cy_s = PIX_W'($signed(head_job.cy));
    a_s  = PIX_W'($signed(swap ? head_job.y : head_job.x));
    b_s  = PIX_W'($signed(swap ? head_job.x : head_job.y));
    px_s = xneg ? cx_s - a_s : cx_s + a_s;
    py_s = yneg ? cy_s - b_s : cy_s + b_s;
    in_frame = cfg.draw_en && !head_job.empty && !px_s[PIX_W-1] && !py_s[PIX_W-1]
            && (px_s[PIX_W-2:0] < (PIX_W-1)'(cfg.width))
            && (py_s[PIX_W-2:0] < (PIX_W-1)'(cfg.height));

    sum     = SUM_W'(prod2_r) + SUM_W'(px2_r);
    we3_nxt = we2_r && (sum < SUM_W'(MAX_PIXELS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      if (issue) pt_r <= last_pt ? 3'd0 : pt_r + 3'd1;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      we1_r    <= in_frame;
      px1_r    <= px_s[DIM_W-1:0];
      py1_r    <= py_s[DIM_W-1:0];
      color1_r <= head_job.empty ? '0 : head_job.color;
      last1_r  <= last_pt;
      done1_r  <= head_job.empty || (last_pt && head_job.done);

      we2_r    <= we1_r;
      px2_r    <= px1_r;
      prod2_r  <= (2*DIM_W)'(py1_r) * (2*DIM_W)'(cfg.pitch);
      color2_r <= color1_r;
      last2_r  <= last1_r;
      done2_r  <= done1_r;

      we3_r    <= we3_nxt;
      idx3_r   <= we3_nxt ? sum[INDEX_W-1:0] : '0;
      color3_r <= color2_r;
      last3_r  <= last2_r;
      done3_r  <= done2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {3'b000, color3_r, idx3_r, we3_r};
  assign out_tlast  = last3_r;
  assign out_tuser  = done3_r;

endmodule
`default_nettype wire

// ===== src/midpoint_circle_raster.sv =====
// Midpoint circle outline rasterizer: emits clipped frame-buffer pixel writes.
// Channels: in_* takes one item (tuser = action: 0 start, 1 step; tdata = center_x,
// center_y, radius, draw_color). out_* gives results (tdata = write_enable,
// pixel_index, pixel_color; tlast = last result of the item; tuser = circle_done).
// cfg_* writes registers: 0 drawing enable, 1 frame width, 2 frame height, 3 line pitch.
// A start or step item yields eight point writes in octant order, one per cycle unless
// the output stalls; a negative-radius start or a step with no circle running yields
// one empty result. The point walker can take the next queued item as soon as the last
// point of the current one issues. Each result passes the queue, then the select/clip,
// multiply and add stages into the output register.
// The front end updates the recurrence in the cycle it accepts an item and parks the
// job in a 4-entry queue, so items are taken back to back until the queue fills.
// When out_tready is low with a result waiting, the whole point pipeline holds; in_tready
// drops only when the queue is full. Reset clears the circle state, the queue pointers,
// the configuration registers and the pipeline valid bits; point data is not cleared.
`default_nettype none
module midpoint_circle_raster (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [mcr_pkg::IN_DATA_W-1:0]  in_tdata,   // center_x, center_y, radius, draw_color
  input  wire                            in_tuser,   // action
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [mcr_pkg::OUT_DATA_W-1:0] out_tdata,  // write_enable, pixel_index, pixel_color
  output logic                           out_tlast,  // last_of_run
  output logic                           out_tuser,  // circle_done
  input  wire                            cfg_we,
  input  wire  [mcr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire  [mcr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcr_pkg::*;

  cfg_t cfg_r;
  job_t front_job, head_job;
  logic push, full, pop, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DRAW_EN: cfg_r.draw_en <= cfg_data[0];
        REG_WIDTH:   cfg_r.width   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:  cfg_r.height  <= cfg_data[DIM_W-1:0];
        REG_PITCH:   cfg_r.pitch   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !full;
  assign push      = in_tvalid && !full;

  mcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .action     (in_tuser),
    .center_x   (in_tdata[13:0]),
    .center_y   (in_tdata[27:14]),
    .radius     (in_tdata[41:28]),
    .draw_color (in_tdata[73:42]),
    .job        (front_job)
  );

  mcr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (front_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
